// ===== design/cps_pkg.sv =====
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants for the concavity point search block.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int COORD_BITS    = 12;
    localparam int ADDR_BITS     = $clog2(MAX_POINTS);
    localparam int COUNT_BITS    = ADDR_BITS + 1;
    localparam int CURV_BITS     = 16;
    localparam int MD_BITS       = 8;
    localparam int SPAN_BITS     = 6;
    localparam int CNT_BITS      = SPAN_BITS + 1;
    localparam int SUM_BITS      = COORD_BITS + SPAN_BITS;
    localparam int FRAC_BITS     = 4;
    localparam int DIVIDEND_BITS = SUM_BITS + FRAC_BITS;
    localparam int INDEX_BITS    = 10;
    localparam int MEAN_BITS     = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    // floor(2n/5) as (n * 13108) >> 15
    localparam int B_MULT        = 13108;
    localparam int B_MULT_BITS   = 14;
    localparam int B_SHIFT       = 15;
    localparam int B_PROD_BITS   = COUNT_BITS + B_MULT_BITS;

    localparam logic signed [CURV_BITS-1:0] RST_THRESHOLD = '0;
    localparam logic [MD_BITS-1:0]          RST_MIN_DIST  = MD_BITS'(10);
    localparam logic [SPAN_BITS-1:0]        RST_SPAN      = SPAN_BITS'(10);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD    = 2'd0,
        CFG_MIN_DISTANCE = 2'd1,
        CFG_SUPPORT_SPAN = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [11:0]        point_x;
        logic [11:0]        point_y;
        logic signed [15:0] curvature;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic        low_found;
        logic [9:0]  low_index;
        logic        high_found;
        logic [9:0]  high_index;
        logic [15:0] low_support_x;
        logic [15:0] low_support_y;
        logic [15:0] high_support_x;
        logic [15:0] high_support_y;
    } t_out_item;

    typedef struct packed {
        logic signed [CURV_BITS-1:0] curv;
        logic [COORD_BITS-1:0]       y;
        logic [COORD_BITS-1:0]       x;
    } t_entry;

    typedef enum logic [3:0] {
        S_LOAD,
        S_BOUND,
        S_FWD_INIT,
        S_BWD_INIT,
        S_CHECK,
        S_READ,
        S_EV1,
        S_EV2,
        S_EV3,
        S_LAVG_INIT,
        S_HAVG_INIT,
        S_ARD,
        S_AACC,
        S_DIV,
        S_DIV_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic bound;
        logic fwd_init;
        logic bwd_init;
        logic step;
        logic found;
        logic low_avg_init;
        logic high_avg_init;
        logic acc_add;
        logic idx_inc;
        logic div_start;
        logic div_store;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_range;
        logic reject;
        logic at_last;
        logic div_done;
        logic low_found;
        logic high_avg_ok;
        logic dir;
    } t_status;

endpackage

// ===== design/concavity_point_search.sv =====
// ----------------------------------------------------------------------------
// concavity_point_search
// Loads a closed contour and finds its forward and backward concavity points
// with the mean coordinates of their neighbours.
//
//  Channel | Dir | Handshake                  | Payload
//  in      | in  | i_in_valid / o_in_ready    | cps_pkg::t_in_item, one point
//  out     | out | o_out_valid / i_out_ready  | cps_pkg::t_out_item
//  cfg     | in  | i_cfg_we                   | i_cfg_index, i_cfg_data
//
//  Points load one a beat, one per cycle, into the point store.
//  After the last point: scan bound, forward scan, backward scan; each tested
//  point passes the check, read and evaluation states. Each averaged side
//  then sums its points and divides in the shared restoring divider; the
//  registered read and the distance pipeline set the scan pace.
//  Input is held off from the closing point until the result is registered;
//  the result waits in an output register while the next contour loads.
//  Reset clears count, found flags, control; sets cfg defaults; keeps the store.
// ----------------------------------------------------------------------------
module concavity_point_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  cps_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output cps_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [cps_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);

    cps_pkg::t_cmd    w_cmd;
    cps_pkg::t_status w_status;

    cps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.last_point),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    cps_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/cps_div.sv =====
// ----------------------------------------------------------------------------
// cps_div
// Two-lane restoring divider sharing one divisor, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cps_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [cps_pkg::DIVIDEND_BITS-1:0]  i_dividend_x,
    input  logic [cps_pkg::DIVIDEND_BITS-1:0]  i_dividend_y,
    input  logic [cps_pkg::CNT_BITS-1:0]       i_divisor,
    output logic                               o_done,
    output logic [cps_pkg::DIVIDEND_BITS-1:0]  o_quot_x,
    output logic [cps_pkg::DIVIDEND_BITS-1:0]  o_quot_y
);

    localparam int DW   = cps_pkg::DIVIDEND_BITS;
    localparam int RW   = cps_pkg::CNT_BITS;
    localparam int ITW  = $clog2(DW);

    logic          r_busy;
    logic          r_done;
    logic [ITW-1:0] r_iter;
    logic [RW-1:0] r_div;
    logic [DW-1:0] r_qx, r_qy;
    logic [RW-1:0] r_rx, r_ry;

    logic [RW:0]   w_tx, w_ty;
    logic          w_bx, w_by;

    always_comb begin
        w_tx = {r_rx, r_qx[DW-1]};
        w_ty = {r_ry, r_qy[DW-1]};
        w_bx = (w_tx >= {1'b0, r_div});
        w_by = (w_ty >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= r_busy && (r_iter == ITW'(DW - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + ITW'(1);
                if (r_iter == ITW'(DW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_qx  <= i_dividend_x;
            r_qy  <= i_dividend_y;
            r_rx  <= '0;
            r_ry  <= '0;
        end else if (r_busy) begin
            r_qx <= {r_qx[DW-2:0], w_bx};
            r_qy <= {r_qy[DW-2:0], w_by};
            r_rx <= w_bx ? RW'(w_tx - {1'b0, r_div}) : RW'(w_tx);
            r_ry <= w_by ? RW'(w_ty - {1'b0, r_div}) : RW'(w_ty);
        end
    end

    assign o_done   = r_done;
    assign o_quot_x = r_qx;
    assign o_quot_y = r_qy;

endmodule

// ===== design/cps_datapath.sv =====
// ----------------------------------------------------------------------------
// cps_datapath
// Point store, configuration, scan evaluation, averaging and result register.
// ----------------------------------------------------------------------------
module cps_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cps_pkg::t_cmd                       i_cmd,
    output cps_pkg::t_status                    o_status,
    input  cps_pkg::t_in_item                   i_in_data,
    input  logic                                i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [cps_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output cps_pkg::t_out_item                  o_out_data
);

    localparam int AW  = cps_pkg::ADDR_BITS;
    localparam int NW  = cps_pkg::COUNT_BITS;
    localparam int CB  = cps_pkg::COORD_BITS;
    localparam int KW  = cps_pkg::CNT_BITS;
    localparam int SW  = cps_pkg::SUM_BITS;
    localparam int PB  = cps_pkg::B_PROD_BITS;
    localparam int DW  = cps_pkg::DIVIDEND_BITS;
    localparam int MW  = cps_pkg::MEAN_BITS;
    localparam int QW  = 2 * CB;
    localparam int D2W = QW + 1;
    localparam int M2W = 2 * cps_pkg::MD_BITS;

    cps_pkg::t_entry mem [cps_pkg::MAX_POINTS];
    cps_pkg::t_entry r_rd;

    logic signed [cps_pkg::CURV_BITS-1:0] r_thr;
    logic [cps_pkg::MD_BITS-1:0]          r_md;
    logic [cps_pkg::SPAN_BITS-1:0]        r_span;

    logic [NW-1:0]  r_count;
    logic [CB-1:0]  r_x0, r_y0;
    logic [NW-1:0]  r_b;
    logic [M2W-1:0] r_md2;
    logic [AW-1:0]  r_idx;
    logic [AW-1:0]  r_last;
    logic           r_dir;
    logic [KW-1:0]  r_cnt;
    logic [SW-1:0]  r_sum_x, r_sum_y;

    logic [CB-1:0]  r_dx, r_dy;
    logic           r_curv_rej;
    logic [QW-1:0]  r_sqx, r_sqy;

    logic           r_low_found, r_high_found;
    logic [AW-1:0]  r_low_idx, r_high_idx;
    logic [MW-1:0]  r_lsx, r_lsy, r_hsx, r_hsy;

    cps_pkg::t_out_item r_out;

    logic [PB-1:0]  w_b_prod;
    logic [D2W-1:0] w_d2;
    logic           w_in_fwd, w_in_bwd;
    logic [AW-1:0]  w_lo;
    logic [NW-1:0]  w_hi_end, w_hi_lim;
    logic           w_div_done;
    logic [DW-1:0]  w_qx, w_qy;
    logic           w_wr_en;

    cps_pkg::t_entry w_wr;

    always_comb begin
        w_b_prod = PB'(r_count) * PB'(cps_pkg::B_MULT);
        w_d2     = D2W'(r_sqx) + D2W'(r_sqy);
        w_in_fwd = NW'(r_idx) < r_b;
        w_in_bwd = (r_count >= NW'(2)) &&
                   ((NW + 1)'(r_idx) + (NW + 1)'(r_b) > (NW + 1)'(r_count));
        w_lo     = (r_low_idx >= AW'(r_span)) ? r_low_idx - AW'(r_span) : '0;
        w_hi_end = NW'(r_high_idx) + NW'(r_span);
        w_hi_lim = (w_hi_end > r_count) ? r_count : w_hi_end;
        w_wr_en  = i_cmd.load && (r_count < NW'(cps_pkg::MAX_POINTS));
        w_wr.x    = i_in_data.point_x[CB-1:0];
        w_wr.y    = i_in_data.point_y[CB-1:0];
        w_wr.curv = i_in_data.curvature;
    end

    always_comb begin
        o_status.in_range    = r_dir ? w_in_bwd : w_in_fwd;
        o_status.reject      = r_curv_rej || (w_d2 < D2W'(r_md2));
        o_status.at_last     = (r_idx == r_last);
        o_status.div_done    = w_div_done;
        o_status.low_found   = r_low_found;
        o_status.high_avg_ok = r_high_found && (r_span != '0);
        o_status.dir         = r_dir;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[r_count[AW-1:0]] <= w_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= cps_pkg::RST_THRESHOLD;
            r_md   <= cps_pkg::RST_MIN_DIST;
            r_span <= cps_pkg::RST_SPAN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cps_pkg::CFG_THRESHOLD:    r_thr  <= i_cfg_data;
                cps_pkg::CFG_MIN_DISTANCE: r_md   <= i_cfg_data[cps_pkg::MD_BITS-1:0];
                cps_pkg::CFG_SUPPORT_SPAN: r_span <= i_cfg_data[cps_pkg::SPAN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.out_load) begin
            r_count <= '0;
        end else if (w_wr_en) begin
            r_count <= r_count + NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en && (r_count == '0)) begin
            r_x0 <= w_wr.x;
            r_y0 <= w_wr.y;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx       <= (r_rd.x > r_x0) ? r_rd.x - r_x0 : r_x0 - r_rd.x;
        r_dy       <= (r_rd.y > r_y0) ? r_rd.y - r_y0 : r_y0 - r_rd.y;
        r_curv_rej <= r_rd.curv > r_thr;
        r_sqx      <= QW'(r_dx) * QW'(r_dx);
        r_sqy      <= QW'(r_dy) * QW'(r_dy);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bound) begin
            r_b   <= w_b_prod[cps_pkg::B_SHIFT +: NW];
            r_md2 <= M2W'(r_md) * M2W'(r_md);
        end
        if (i_cmd.fwd_init) begin
            r_idx <= AW'(1);
            r_dir <= 1'b0;
        end else if (i_cmd.bwd_init) begin
            r_idx <= AW'(r_count - NW'(2));
            r_dir <= 1'b1;
        end else if (i_cmd.step) begin
            r_idx <= r_dir ? r_idx - AW'(1) : r_idx + AW'(1);
        end else if (i_cmd.low_avg_init) begin
            r_idx  <= w_lo;
            r_last <= r_low_idx;
            r_cnt  <= KW'(r_low_idx - w_lo) + KW'(1);
            r_dir  <= 1'b0;
        end else if (i_cmd.high_avg_init) begin
            r_idx  <= r_high_idx;
            r_last <= AW'(w_hi_lim - NW'(1));
            r_cnt  <= KW'(w_hi_lim - NW'(r_high_idx));
            r_dir  <= 1'b1;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.low_avg_init || i_cmd.high_avg_init) begin
            r_sum_x <= '0;
            r_sum_y <= '0;
        end else if (i_cmd.acc_add) begin
            r_sum_x <= r_sum_x + SW'(r_rd.x);
            r_sum_y <= r_sum_y + SW'(r_rd.y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_found  <= 1'b0;
            r_high_found <= 1'b0;
        end else if (i_cmd.bound) begin
            r_low_found  <= 1'b0;
            r_high_found <= 1'b0;
        end else if (i_cmd.found) begin
            if (r_dir) begin
                r_high_found <= 1'b1;
            end else begin
                r_low_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bound) begin
            r_low_idx  <= '0;
            r_high_idx <= '0;
            r_lsx      <= '0;
            r_lsy      <= '0;
            r_hsx      <= '0;
            r_hsy      <= '0;
        end else begin
            if (i_cmd.found) begin
                if (r_dir) begin
                    r_high_idx <= r_idx;
                end else begin
                    r_low_idx <= r_idx;
                end
            end
            if (i_cmd.div_store) begin
                if (r_dir) begin
                    r_hsx <= w_qx[MW-1:0];
                    r_hsy <= w_qy[MW-1:0];
                end else begin
                    r_lsx <= w_qx[MW-1:0];
                    r_lsy <= w_qy[MW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.low_found      <= r_low_found;
            r_out.low_index      <= r_low_idx[cps_pkg::INDEX_BITS-1:0];
            r_out.high_found     <= r_high_found;
            r_out.high_index     <= r_high_idx[cps_pkg::INDEX_BITS-1:0];
            r_out.low_support_x  <= r_lsx;
            r_out.low_support_y  <= r_lsy;
            r_out.high_support_x <= r_hsx;
            r_out.high_support_y <= r_hsy;
        end
    end

    cps_div u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_cmd.div_start),
        .i_dividend_x ({r_sum_x, {cps_pkg::FRAC_BITS{1'b0}}}),
        .i_dividend_y ({r_sum_y, {cps_pkg::FRAC_BITS{1'b0}}}),
        .i_divisor    (r_cnt),
        .o_done       (w_div_done),
        .o_quot_x     (w_qx),
        .o_quot_y     (w_qy)
    );

    assign o_out_data = r_out;

endmodule

// ===== design/cps_ctrl.sv =====
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer for loading, both scans, averaging and result hand-off.
// ----------------------------------------------------------------------------
module cps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  cps_pkg::t_status i_status,
    output cps_pkg::t_cmd    o_cmd
);

    cps_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cps_pkg::S_LOAD: begin
                if (i_in_valid && i_in_last) n_state = cps_pkg::S_BOUND;
            end
            cps_pkg::S_BOUND:    n_state = cps_pkg::S_FWD_INIT;
            cps_pkg::S_FWD_INIT: n_state = cps_pkg::S_CHECK;
            cps_pkg::S_BWD_INIT: n_state = cps_pkg::S_CHECK;
            cps_pkg::S_CHECK: begin
                if (i_status.in_range) n_state = cps_pkg::S_READ;
                else if (i_status.dir) n_state = cps_pkg::S_LAVG_INIT;
                else n_state = cps_pkg::S_BWD_INIT;
            end
            cps_pkg::S_READ: n_state = cps_pkg::S_EV1;
            cps_pkg::S_EV1:  n_state = cps_pkg::S_EV2;
            cps_pkg::S_EV2:  n_state = cps_pkg::S_EV3;
            cps_pkg::S_EV3: begin
                if (i_status.reject) n_state = cps_pkg::S_CHECK;
                else if (i_status.dir) n_state = cps_pkg::S_LAVG_INIT;
                else n_state = cps_pkg::S_BWD_INIT;
            end
            cps_pkg::S_LAVG_INIT: begin
                n_state = i_status.low_found ? cps_pkg::S_ARD : cps_pkg::S_HAVG_INIT;
            end
            cps_pkg::S_HAVG_INIT: begin
                n_state = i_status.high_avg_ok ? cps_pkg::S_ARD : cps_pkg::S_DONE;
            end
            cps_pkg::S_ARD: n_state = cps_pkg::S_AACC;
            cps_pkg::S_AACC: begin
                n_state = i_status.at_last ? cps_pkg::S_DIV : cps_pkg::S_ARD;
            end
            cps_pkg::S_DIV: n_state = cps_pkg::S_DIV_WAIT;
            cps_pkg::S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    n_state = i_status.dir ? cps_pkg::S_DONE : cps_pkg::S_HAVG_INIT;
                end
            end
            cps_pkg::S_DONE: begin
                if (w_out_free) n_state = cps_pkg::S_LOAD;
            end
            default: n_state = cps_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            cps_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            cps_pkg::S_BOUND:    o_cmd.bound    = 1'b1;
            cps_pkg::S_FWD_INIT: o_cmd.fwd_init = 1'b1;
            cps_pkg::S_BWD_INIT: o_cmd.bwd_init = 1'b1;
            cps_pkg::S_EV3: begin
                o_cmd.step  = i_status.reject;
                o_cmd.found = !i_status.reject;
            end
            cps_pkg::S_LAVG_INIT: o_cmd.low_avg_init  = i_status.low_found;
            cps_pkg::S_HAVG_INIT: o_cmd.high_avg_init = i_status.high_avg_ok;
            cps_pkg::S_AACC: begin
                o_cmd.acc_add = 1'b1;
                o_cmd.idx_inc = !i_status.at_last;
            end
            cps_pkg::S_DIV:      o_cmd.div_start = 1'b1;
            cps_pkg::S_DIV_WAIT: o_cmd.div_store = i_status.div_done;
            cps_pkg::S_DONE:     o_cmd.out_load  = w_out_free;
            default: ;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cps_pkg::S_LOAD;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/cps_checker.sv =====
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks for the concavity point search block.
// ----------------------------------------------------------------------------
module cps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input cps_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input cps_pkg::t_out_item o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    a_low_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.low_found |->
            o_out_data.low_index == '0 && o_out_data.low_support_x == '0 &&
            o_out_data.low_support_y == '0)
        else $error("forward fields set without a forward point");

    a_high_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.high_found |->
            o_out_data.high_index == '0 && o_out_data.high_support_x == '0 &&
            o_out_data.high_support_y == '0)
        else $error("backward fields set without a backward point");

    a_low_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.low_found |-> o_out_data.low_index != '0)
        else $error("forward point at index zero");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_data.last_point |=> !o_in_ready)
        else $error("input still open after the closing point");

endmodule

bind concavity_point_search cps_checker u_cps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
